/* src/complementary_tilt_filter_core_defines.svh */
// ----------------------------------------------------------------------------
// complementary tilt filter assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef COMPLEMENTARY_TILT_FILTER_CORE_DEFINES_SVH
`define COMPLEMENTARY_TILT_FILTER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define CTF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ctf_pkg.sv */
// ----------------------------------------------------------------------------
// ctf_pkg
// shared constants, types and arithmetic helpers of the tilt filter
// ----------------------------------------------------------------------------
package ctf_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  localparam int TABLE_LEN  = 24;
  localparam int TABLE_FRAC = 24;
  localparam int PRESCALE_SHIFT = 14;

  localparam int TILT_W   = 26;
  localparam int OFFSET_W = 24;
  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 16;

  localparam int GYRO_DIV_W = 27;
  localparam logic [GYRO_DIV_W-1:0] GYRO_DIV  = 27'd131000000;
  localparam logic [GYRO_DIV_W-1:0] GYRO_HALF = 27'd65500000;

  localparam logic [WEIGHT_W-1:0] ALPHA_RESET  = 16'd64225;
  localparam logic [WEIGHT_W-1:0] PERIOD_RESET = 16'd1000;

  localparam longint SAT_HI = 64'sd33554431;
  localparam longint SAT_LO = -64'sd33554432;

  // arctangent of 2^-i in degrees, Q.24
  localparam longint ATAN_DEG_Q24 [TABLE_LEN] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  typedef enum logic [1:0] {
    REG_ALPHA,
    REG_PERIOD,
    REG_OFFSET_X,
    REG_OFFSET_Y
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic take;
  } lane_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

  // table entry rounded half up to the angle fraction
  function automatic longint atan_entry(input int idx, input int frac);
    int     sh;
    longint t;
    sh = TABLE_FRAC - frac;
    if (idx >= TABLE_LEN || idx < 0) begin
      return 0;
    end
    t = ATAN_DEG_Q24[idx];
    return (t + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [TILT_W-1:0] sat_tilt(input logic signed [63:0] v);
    logic signed [TILT_W-1:0] r;
    if (v > SAT_HI) begin
      r = TILT_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = TILT_W'(SAT_LO);
    end else begin
      r = v[TILT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/complementary_tilt_filter_core.sv */
// ----------------------------------------------------------------------------
// complementary_tilt_filter_core
// two-axis complementary tilt filter with a register port
// ----------------------------------------------------------------------------
// in_*  : one inertial sample per transfer (three accel words, two gyro rates)
// out_* : one result per sample, fused x and y tilt plus offset, Q.16 degrees
// cfg_* : register port, alpha, sample period and the two offsets
// two lanes, one per axis, run side by side; each runs its own cordic and
// divides the gyro term by a reciprocal multiply with a short correction
// out_tvalid rises after the cordic is done and the blend, offset
// and output registers are passed; the divide ends well inside the cordic run
// one sample is in flight in the lanes, so a new input transfer waits until
// both lanes have handed their results to the output register
// a result sits in an output register; while the receiver stalls the lanes
// may take one more sample, then hold their results with in_tready low
// reset clears the kept angles and loads the register defaults
module complementary_tilt_filter_core #(
  parameter int CORDIC_STEPS    = ctf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ctf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, 16 bits each
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tilt_x, tilt_y, 26 bits each, zero pad
  output logic [55:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int TW = ctf_pkg::TILT_W;

  logic [ctf_pkg::WEIGHT_W-1:0]        alpha_r, alpha_nxt, period_r, period_nxt;
  logic signed [ctf_pkg::OFFSET_W-1:0] offx_r, offx_nxt, offy_r, offy_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [55:0]                         out_data_r, out_data_nxt;

  ctf_pkg::lane_ctl_t  ctl;
  ctf_pkg::lane_stat_t stat_x, stat_y;
  ctf_pkg::reg_idx_t   idx;
  logic signed [TW-1:0] tilt_x, tilt_y;
  logic cfg_wr, take;

  assign cfg_pready = 1'b1;
  assign idx        = ctf_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  assign in_tready = stat_x.idle && stat_y.idle;
  assign take      = stat_x.done && stat_y.done && (!out_valid_r || out_tready);
  assign ctl.start = in_tvalid && in_tready;
  assign ctl.take  = take;

  always_comb begin
    alpha_nxt  = alpha_r;
    period_nxt = period_r;
    offx_nxt   = offx_r;
    offy_nxt   = offy_r;
    if (cfg_wr) begin
      case (idx)
        ctf_pkg::REG_ALPHA:    alpha_nxt  = cfg_pwdata[15:0];
        ctf_pkg::REG_PERIOD:   period_nxt = cfg_pwdata[15:0];
        ctf_pkg::REG_OFFSET_X: offx_nxt   = cfg_pwdata[23:0];
        ctf_pkg::REG_OFFSET_Y: offy_nxt   = cfg_pwdata[23:0];
        default: ;
      endcase
    end
    case (idx)
      ctf_pkg::REG_ALPHA:    cfg_prdata = 32'(alpha_r);
      ctf_pkg::REG_PERIOD:   cfg_prdata = 32'(period_r);
      ctf_pkg::REG_OFFSET_X: cfg_prdata = 32'(offx_r);
      ctf_pkg::REG_OFFSET_Y: cfg_prdata = 32'(offy_r);
      default:               cfg_prdata = '0;
    endcase

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'b0, tilt_y, tilt_x};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= ctf_pkg::ALPHA_RESET;
      period_r    <= ctf_pkg::PERIOD_RESET;
      offx_r      <= '0;
      offy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      alpha_r     <= alpha_nxt;
      period_r    <= period_nxt;
      offx_r      <= offx_nxt;
      offy_r      <= offy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  // x axis tilts on accel y over z, y axis on accel x over z
  ctf_lane #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_lane_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .accel_num(in_tdata[31:16]),
    .accel_den(in_tdata[47:32]),
    .rate     (in_tdata[63:48]),
    .alpha    (alpha_r),
    .period   (period_r),
    .offset   (offx_r),
    .stat     (stat_x),
    .tilt     (tilt_x)
  );

  ctf_lane #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_lane_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .accel_num(in_tdata[15:0]),
    .accel_den(in_tdata[47:32]),
    .rate     (in_tdata[79:64]),
    .alpha    (alpha_r),
    .period   (period_r),
    .offset   (offy_r),
    .stat     (stat_y),
    .tilt     (tilt_y)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* src/ctf_cordic.sv */
// ----------------------------------------------------------------------------
// ctf_cordic
// iterative vectoring cordic, atan2(y, x) in fixed point degrees
// ----------------------------------------------------------------------------
module ctf_cordic #(
  parameter int CORDIC_STEPS    = ctf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ctf_pkg::ANGLE_FRAC_BITS_DEF,
  localparam int AW = ANGLE_FRAC_BITS + 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0] y_in,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0] x_in,
  output logic                              done,
  output logic signed [AW-1:0]              angle
);

  localparam int XW = 33;
  localparam int CW = $clog2(CORDIC_STEPS);
  localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);
  localparam logic signed [AW-1:0] HALF_TURN = AW'(180 << ANGLE_FRAC_BITS);

  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [AW-1:0] z_r, z_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 run_r, run_nxt, done_r, done_nxt, zero_r, zero_nxt;

  logic signed [16:0]   xs, ys;
  logic signed [XW-1:0] dx, dy;
  logic signed [AW-1:0] step_a;

  always_comb begin
    xs       = 17'(x_in);
    ys       = 17'(y_in);
    dx       = y_r >>> cnt_r;
    dy       = x_r >>> cnt_r;
    step_a   = AW'(ctf_pkg::atan_entry(int'(cnt_r), ANGLE_FRAC_BITS));
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    zero_nxt = zero_r;
    if (start) begin
      zero_nxt = (x_in == '0) && (y_in == '0);
      // left half plane is folded over by half a turn first
      if (xs < 0) begin
        xs    = -xs;
        ys    = -ys;
        z_nxt = (y_in >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
        z_nxt = '0;
      end
      x_nxt    = XW'(xs) <<< ctf_pkg::PRESCALE_SHIFT;
      y_nxt    = XW'(ys) <<< ctf_pkg::PRESCALE_SHIFT;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (run_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + step_a;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - step_a;
      end
      if (cnt_r == LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_nxt;
  end

  assign done  = done_r;
  assign angle = zero_r ? '0 : z_r;

endmodule

/* src/ctf_lane.sv */
// ----------------------------------------------------------------------------
// ctf_lane
// one axis: accel tilt, gyro step by reciprocal divide, blend and offset
// ----------------------------------------------------------------------------
module ctf_lane #(
  parameter int CORDIC_STEPS    = ctf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ctf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ctf_pkg::lane_ctl_t                  ctl,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0] accel_num,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0] accel_den,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0] rate,
  input  logic [ctf_pkg::WEIGHT_W-1:0]        alpha,
  input  logic [ctf_pkg::WEIGHT_W-1:0]        period,
  input  logic signed [ctf_pkg::OFFSET_W-1:0] offset,
  output ctf_pkg::lane_stat_t                 stat,
  output logic signed [ctf_pkg::TILT_W-1:0]   tilt
);

  localparam int AW  = ANGLE_FRAC_BITS + 10;
  localparam int NW  = 32 + ANGLE_FRAC_BITS;
  localparam int QW  = ANGLE_FRAC_BITS + 6;
  localparam int EW  = 32 + QW;
  localparam int MW  = ctf_pkg::GYRO_DIV_W + 2;
  localparam int SW  = (ANGLE_FRAC_BITS + 8 > 27) ? ANGLE_FRAC_BITS + 8 : 27;
  localparam int PW  = ((SW + 17 > AW + 18) ? SW + 17 : AW + 18) + 1;
  localparam int TW  = ctf_pkg::TILT_W;
  // floor(2^(frac + 32) / divisor), applied to the top 32 dividend bits
  localparam longint RECIP_L =
    (longint'(1) <<< (ANGLE_FRAC_BITS + 32)) / longint'(ctf_pkg::GYRO_DIV);
  localparam logic [QW-1:0] RECIP = QW'(RECIP_L);

  typedef enum logic [2:0] {
    L_IDLE, L_EST, L_REM, L_FIX, L_MUL, L_BLEND, L_OFFS, L_DONE
  } lane_state_t;

  lane_state_t state_r, state_nxt;
  logic [31:0]           prod_r, prod_nxt;
  logic                  neg_r, neg_nxt;
  logic [MW-1:0]         rem_r, rem_nxt;
  logic [QW-1:0]         quo_r, quo_nxt;
  logic signed [PW-1:0]  pa_r, pa_nxt, pb_r, pb_nxt;
  logic signed [TW-1:0]  kept_r, kept_nxt, tilt_r, tilt_nxt;

  logic                  cordic_done;
  logic signed [AW-1:0]  accel_ang;
  logic [15:0]           mag;
  logic [NW-1:0]         num;
  logic [EW-1:0]         est;
  logic signed [SW-1:0]  step, sum;
  logic signed [16:0]    alpha_s;
  logic signed [17:0]    beta_s;
  logic signed [PW-1:0]  v;
  logic signed [26:0]    osum;

  ctf_cordic #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .start(ctl.start && (state_r == L_IDLE)),
    .y_in (accel_num),
    .x_in (accel_den),
    .done (cordic_done),
    .angle(accel_ang)
  );

  always_comb begin
    mag     = rate[15] ? 16'(-rate) : 16'(rate);
    // rounding half is folded into the dividend
    num     = (NW'(prod_r) << ANGLE_FRAC_BITS) + NW'(ctf_pkg::GYRO_HALF);
    est     = EW'(num[NW-1:ANGLE_FRAC_BITS]) * EW'(RECIP);
    step    = signed'(SW'(quo_r));
    if (neg_r) begin
      step = -step;
    end
    sum     = SW'(kept_r) + step;
    alpha_s = signed'({1'b0, alpha});
    beta_s  = 18'sd65536 - signed'({2'b0, alpha});
    v       = pa_r + pb_r + PW'(32768);
    osum    = 27'(kept_r) + 27'(offset);

    state_nxt = state_r;
    prod_nxt  = prod_r;
    neg_nxt   = neg_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    kept_nxt  = kept_r;
    tilt_nxt  = tilt_r;

    case (state_r)
      L_IDLE: begin
        if (ctl.start) begin
          prod_nxt  = 32'(mag) * 32'(period);
          neg_nxt   = rate[15];
          state_nxt = L_EST;
        end
      end
      L_EST: begin
        quo_nxt   = est[EW-1:32];
        state_nxt = L_REM;
      end
      L_REM: begin
        rem_nxt   = MW'(num - NW'(quo_r) * NW'(ctf_pkg::GYRO_DIV));
        state_nxt = L_FIX;
      end
      L_FIX: begin
        // the estimate falls short of the quotient by at most two
        if (rem_r >= MW'(ctf_pkg::GYRO_DIV)) begin
          rem_nxt = rem_r - MW'(ctf_pkg::GYRO_DIV);
          quo_nxt = quo_r + 1'b1;
        end else if (cordic_done) begin
          state_nxt = L_MUL;
        end
      end
      L_MUL: begin
        pa_nxt    = PW'(sum) * PW'(alpha_s);
        pb_nxt    = PW'(accel_ang) * PW'(beta_s);
        state_nxt = L_BLEND;
      end
      L_BLEND: begin
        kept_nxt  = ctf_pkg::sat_tilt(64'(v >>> 16));
        state_nxt = L_OFFS;
      end
      L_OFFS: begin
        tilt_nxt  = ctf_pkg::sat_tilt(64'(osum));
        state_nxt = L_DONE;
      end
      L_DONE: begin
        if (ctl.take) begin
          state_nxt = L_IDLE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      kept_r  <= '0;
    end else begin
      state_r <= state_nxt;
      kept_r  <= kept_nxt;
    end
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    tilt_r <= tilt_nxt;
  end

  assign stat.idle = (state_r == L_IDLE);
  assign stat.done = (state_r == L_DONE);
  assign tilt      = tilt_r;

endmodule

/* src/ctf_checker.sv */
// ----------------------------------------------------------------------------
// ctf_checker
// port-level checks on the tilt filter, bound to the top level
// ----------------------------------------------------------------------------
`include "complementary_tilt_filter_core_defines.svh"

module ctf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        cfg_psel,
  input logic        cfg_pready
);

  // a held result keeps its value
  `CTF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // one sample in flight: busy right after a transfer in
  `CTF_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready, "input taken while busy")

  // pad bits above the two tilts stay clear
  `CTF_ASSERT_SAME(a_pad_zero, out_tvalid, out_tdata[55:52] == 4'b0, "pad bits set")

  // the register port never waits
  `CTF_ASSERT_SAME(a_no_wait, cfg_psel, cfg_pready, "register port stalled")

endmodule

bind complementary_tilt_filter_core ctf_checker u_ctf_checker (.*);
